// File: src/zts_pkg.sv
// ----------------------------------------------------------------------------
// zts_pkg
// Types and constants shared by the Zipf table sampler modules.
// ----------------------------------------------------------------------------
package zts_pkg;

   localparam int KEY_W       = 32;
   localparam int CUM_W       = 48;
   localparam int DRAW_W      = 31;
   localparam int IDX_FIELD_W = 12;
   localparam int EIU_W       = 13;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam int REQ_DATA_W  = 224;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;

   // request tdata layout, lowest bit first
   localparam int IDX_LSB   = 0;
   localparam int CUM_LSB   = IDX_LSB + IDX_FIELD_W;
   localparam int FIRST_LSB = CUM_LSB + CUM_W;
   localparam int COUNT_LSB = FIRST_LSB + KEY_W;
   localparam int HI_LSB    = COUNT_LSB + KEY_W;
   localparam int LO_LSB    = HI_LSB + DRAW_W;
   localparam int PICK_LSB  = LO_LSB + DRAW_W;

   localparam logic [CUM_W-1:0] TOTAL_WEIGHT_RESET = 48'h0001_0000_0000;
   localparam logic [EIU_W-1:0] ENTRIES_RESET      = 13'd4096;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   // register select is byte address bit 3
   typedef enum logic {
      CSR_TOTAL_WEIGHT = 1'b0,
      CSR_ENTRIES      = 1'b1
   } csr_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SEARCH,
      ST_COMPARE,
      ST_FETCH,
      ST_PICK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CUM_W-1:0] cumulative;
      logic [KEY_W-1:0] first_key;
      logic [KEY_W-1:0] key_count;
   } entry_type;

   typedef struct packed {
      logic             done;
      logic [KEY_W-1:0] remainder;
   } mod_status_type;

endpackage

// File: src/zts_ram.sv
// ----------------------------------------------------------------------------
// zts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module zts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/zts_scaler.sv
// ----------------------------------------------------------------------------
// zts_scaler
// Computes floor(v * total_weight / 2^62) with one 32x32 multiplier over
// four partial products and a shifted accumulate.
// ----------------------------------------------------------------------------
module zts_scaler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2*zts_pkg::DRAW_W-1:0]   draw,
   input  logic [zts_pkg::CUM_W-1:0]      weight,
   output logic                           done,
   output logic [zts_pkg::CUM_W-1:0]      target
);

   localparam int ACC_W  = 2 * zts_pkg::DRAW_W + zts_pkg::CUM_W;
   localparam int HALF_W = 32;

   logic [2*zts_pkg::DRAW_W-1:0] draw_ff;
   logic [zts_pkg::CUM_W-1:0]    weight_ff;
   logic                         busy_ff;
   logic [2:0]                   step_ff;
   logic [1:0]                   prod_sel_ff;
   logic [2*HALF_W-1:0]          prod_ff;
   logic [ACC_W-1:0]             acc_ff;
   logic                         done_ff;

   logic [HALF_W-1:0]  op_a;
   logic [HALF_W-1:0]  op_b;
   logic [ACC_W-1:0]   addend;
   logic [6:0]         shift;

   always_comb begin
      op_a  = step_ff[1] ? HALF_W'(draw_ff[2*zts_pkg::DRAW_W-1:HALF_W])
                         : draw_ff[HALF_W-1:0];
      op_b  = step_ff[0] ? HALF_W'(weight_ff[zts_pkg::CUM_W-1:HALF_W])
                         : weight_ff[HALF_W-1:0];
      shift = 7'(HALF_W) * (7'(prod_sel_ff[0]) + 7'(prod_sel_ff[1]));
      addend = ACC_W'(prod_ff) << shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         draw_ff   <= draw;
         weight_ff <= weight;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         if (step_ff != 3'd4) begin
            prod_ff     <= op_a * op_b;
            prod_sel_ff <= step_ff[1:0];
         end
         if (step_ff != 3'd0) begin
            acc_ff <= acc_ff + addend;
         end
      end
   end

   assign done   = done_ff;
   assign target = acc_ff[ACC_W-1:ACC_W-zts_pkg::CUM_W];

endmodule

// File: src/zts_mod.sv
// ----------------------------------------------------------------------------
// zts_mod
// Bit-serial restoring remainder of a 31-bit draw by a 32-bit key count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module zts_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [zts_pkg::DRAW_W-1:0]  dividend,
   input  logic [zts_pkg::KEY_W-1:0]   divisor,
   output zts_pkg::mod_status_type     status
);

   localparam int CNT_W = $clog2(zts_pkg::DRAW_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [zts_pkg::DRAW_W-1:0]  dividend_ff;
   logic [zts_pkg::KEY_W-1:0]   divisor_ff;
   logic [zts_pkg::KEY_W-1:0]   rem_ff;

   logic [zts_pkg::KEY_W:0] trial;
   logic [zts_pkg::KEY_W:0] diff;

   always_comb begin
      trial = {rem_ff, dividend_ff[zts_pkg::DRAW_W-1]};
      diff  = trial - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(zts_pkg::DRAW_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
         divisor_ff  <= divisor;
         rem_ff      <= '0;
      end else if (busy_ff) begin
         dividend_ff <= dividend_ff << 1;
         if (trial >= {1'b0, divisor_ff}) begin
            rem_ff <= diff[zts_pkg::KEY_W-1:0];
         end else begin
            rem_ff <= trial[zts_pkg::KEY_W-1:0];
         end
      end
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// File: src/zipf_table_sampler_top.sv
// ----------------------------------------------------------------------------
// zipf_table_sampler_top
// Load transaction: RAM write on accept; ack via result and output registers.
// Sample transaction: four-product scaler, then s search steps, each a RAM
//   read and a compare (s floor or ceil of log2(n), n the clamped
//   entries_in_use), then the bucket fetch through the RAM read port, the
//   bit-serial remainder and the output register.
// One request in flight; the output register lets the next one start.
// Synchronous reset restores control and CSR registers; table contents kept.
// ----------------------------------------------------------------------------
module zipf_table_sampler_top #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, entry_cumulative, entry_first_key, entry_key_count,
   // rand_hi, rand_lo, rand_pick, zero pad
   input  logic [zts_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // sampled_key
   output logic [zts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // is_sample, empty_bucket
   output logic [zts_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [zts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [zts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [zts_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int SPAN_W = $clog2(TABLE_DEPTH + 1);

   zts_pkg::state_type            state_ff, state_in;
   logic [zts_pkg::CUM_W-1:0]     total_weight_ff;
   logic [zts_pkg::EIU_W-1:0]     entries_ff;
   logic [IDX_W-1:0]              base_ff, base_in;
   logic [SPAN_W-1:0]             span_ff, span_in;
   logic [zts_pkg::CUM_W-1:0]     target_ff, target_in;
   logic [zts_pkg::DRAW_W-1:0]    pick_ff, pick_in;
   logic [zts_pkg::KEY_W-1:0]     first_ff, first_in;
   logic [zts_pkg::KEY_W-1:0]     count_ff, count_in;
   logic [zts_pkg::KEY_W-1:0]     res_key_ff, res_key_in;
   logic                          res_sample_ff, res_sample_in;
   logic                          res_empty_ff, res_empty_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [zts_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic                          rsp_sample_ff, rsp_sample_in;
   logic                          rsp_empty_ff, rsp_empty_in;

   logic                          req_accept;
   logic                          csr_write;
   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   zts_pkg::entry_type            ram_wr_data;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   zts_pkg::entry_type            ram_rd_data;
   logic                          scale_start;
   logic                          scale_done;
   logic [zts_pkg::CUM_W-1:0]     scale_target;
   logic                          mod_start;
   zts_pkg::mod_status_type       mod_status;
   logic [31:0]                   idx_ext;
   logic [31:0]                   eiu_ext;
   logic [31:0]                   span_init;
   logic [SPAN_W-1:0]             half;
   logic [IDX_W-1:0]              probe;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_weight_ff <= zts_pkg::TOTAL_WEIGHT_RESET;
         entries_ff      <= zts_pkg::ENTRIES_RESET;
      end else if (csr_write) begin
         unique case (zts_pkg::csr_sel_type'(csr_paddr[3]))
            zts_pkg::CSR_TOTAL_WEIGHT: begin
               total_weight_ff <= csr_pwdata[zts_pkg::CUM_W-1:0];
            end
            zts_pkg::CSR_ENTRIES: begin
               entries_ff <= csr_pwdata[zts_pkg::EIU_W-1:0];
            end
            default: begin
               total_weight_ff <= total_weight_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (zts_pkg::csr_sel_type'(csr_paddr[3]))
         zts_pkg::CSR_TOTAL_WEIGHT: csr_prdata = zts_pkg::CSR_DATA_W'(total_weight_ff);
         zts_pkg::CSR_ENTRIES:      csr_prdata = zts_pkg::CSR_DATA_W'(entries_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // request decode
   assign req_tready = (state_ff == zts_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign idx_ext     = 32'(req_tdata[zts_pkg::IDX_LSB +: zts_pkg::IDX_FIELD_W]);
   assign ram_wr_addr = idx_ext[IDX_W-1:0];
   assign ram_wr_en   = req_accept && (zts_pkg::req_kind_type'(req_tuser[0]) ==
                        zts_pkg::REQ_LOAD) && (idx_ext < 32'(TABLE_DEPTH));
   assign ram_wr_data.cumulative = req_tdata[zts_pkg::CUM_LSB +: zts_pkg::CUM_W];
   assign ram_wr_data.first_key  = req_tdata[zts_pkg::FIRST_LSB +: zts_pkg::KEY_W];
   assign ram_wr_data.key_count  = req_tdata[zts_pkg::COUNT_LSB +: zts_pkg::KEY_W];

   assign scale_start = req_accept &&
                        (zts_pkg::req_kind_type'(req_tuser[0]) == zts_pkg::REQ_SAMPLE);

   // clamp search length to 1..TABLE_DEPTH
   always_comb begin
      eiu_ext = 32'(entries_ff);
      if (eiu_ext == 32'd0) begin
         span_init = 32'd1;
      end else if (eiu_ext > 32'(TABLE_DEPTH)) begin
         span_init = 32'(TABLE_DEPTH);
      end else begin
         span_init = eiu_ext;
      end
   end

   assign half  = span_ff >> 1;
   assign probe = base_ff + IDX_W'(half);

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      span_in       = span_ff;
      target_in     = target_ff;
      pick_in       = pick_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      res_key_in    = res_key_ff;
      res_sample_in = res_sample_ff;
      res_empty_in  = res_empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_key_in    = rsp_key_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_empty_in  = rsp_empty_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = base_ff;
      mod_start     = 1'b0;

      unique case (state_ff)
         zts_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (zts_pkg::req_kind_type'(req_tuser[0]) == zts_pkg::REQ_LOAD) begin
                  res_key_in    = '0;
                  res_sample_in = 1'b0;
                  res_empty_in  = 1'b0;
                  state_in      = zts_pkg::ST_DONE;
               end else begin
                  pick_in  = req_tdata[zts_pkg::PICK_LSB +: zts_pkg::DRAW_W];
                  base_in  = '0;
                  span_in  = span_init[SPAN_W-1:0];
                  state_in = zts_pkg::ST_SCALE;
               end
            end
         end
         zts_pkg::ST_SCALE: begin
            if (scale_done) begin
               target_in = scale_target;
               state_in  = zts_pkg::ST_SEARCH;
            end
         end
         zts_pkg::ST_SEARCH: begin
            ram_rd_en = 1'b1;
            if (span_ff > SPAN_W'(1)) begin
               ram_rd_addr = probe;
               state_in    = zts_pkg::ST_COMPARE;
            end else begin
               ram_rd_addr = base_ff;
               state_in    = zts_pkg::ST_FETCH;
            end
         end
         zts_pkg::ST_COMPARE: begin
            if (ram_rd_data.cumulative > target_ff) begin
               span_in = half;
            end else begin
               base_in = probe;
               span_in = span_ff - half;
            end
            state_in = zts_pkg::ST_SEARCH;
         end
         zts_pkg::ST_FETCH: begin
            first_in  = ram_rd_data.first_key;
            count_in  = ram_rd_data.key_count;
            mod_start = 1'b1;
            state_in  = zts_pkg::ST_PICK;
         end
         zts_pkg::ST_PICK: begin
            if (mod_status.done) begin
               res_sample_in = 1'b1;
               if (count_ff == '0) begin
                  res_key_in   = first_ff;
                  res_empty_in = 1'b1;
               end else begin
                  res_key_in   = first_ff + mod_status.remainder;
                  res_empty_in = 1'b0;
               end
               state_in = zts_pkg::ST_DONE;
            end
         end
         zts_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = res_key_ff;
               rsp_sample_in = res_sample_ff;
               rsp_empty_in  = res_empty_ff;
               state_in      = zts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      span_ff       <= span_in;
      target_ff     <= target_in;
      pick_ff       <= pick_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      res_key_ff    <= res_key_in;
      res_sample_ff <= res_sample_in;
      res_empty_ff  <= res_empty_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = {rsp_empty_ff, rsp_sample_ff};

   zts_ram #(
      .WIDTH ($bits(zts_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   zts_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .draw   ({req_tdata[zts_pkg::HI_LSB +: zts_pkg::DRAW_W],
                req_tdata[zts_pkg::LO_LSB +: zts_pkg::DRAW_W]}),
      .weight (total_weight_ff),
      .done   (scale_done),
      .target (scale_target)
   );

   zts_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (pick_ff),
      .divisor  (ram_rd_data.key_count),
      .status   (mod_status)
   );

   a_scale_done_in_scale : assert property (@(posedge clock) disable iff (reset)
      scale_done |-> (state_ff == zts_pkg::ST_SCALE))
      else $error("scaler finished outside the scale phase");

   a_mod_done_in_pick : assert property (@(posedge clock) disable iff (reset)
      mod_status.done |-> (state_ff == zts_pkg::ST_PICK))
      else $error("remainder unit finished outside the pick phase");

   a_search_in_bounds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == zts_pkg::ST_SEARCH || state_ff == zts_pkg::ST_COMPARE) |->
      ((span_ff != '0) && (32'(base_ff) + 32'(span_ff) <= 32'(TABLE_DEPTH))))
      else $error("search window left the table");

   a_load_ack_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_sample_ff) |-> (!rsp_empty_ff && rsp_key_ff == '0))
      else $error("load acknowledgement carries sample data");

   a_compare_follows_search : assert property (@(posedge clock) disable iff (reset)
      (state_ff == zts_pkg::ST_COMPARE) |-> ($past(state_ff) == zts_pkg::ST_SEARCH))
      else $error("compare without a preceding table read");

endmodule
